// ----- hw/rtl/lit_affine_texture_span_top_defines.svh -----
// ----------------------------------------------------------------------------
// Span engine assertion macros
// Shared concurrent assertion forms for the span engine modules.
// ----------------------------------------------------------------------------
`ifndef LIT_AFFINE_TEXTURE_SPAN_TOP_DEFINES_SVH
`define LIT_AFFINE_TEXTURE_SPAN_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define LATS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define LATS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lats_pkg.sv -----
// ----------------------------------------------------------------------------
// Span engine package
// Types, codes and fixed widths shared by the span engine modules.
// ----------------------------------------------------------------------------
package lats_pkg;

	localparam logic [1:0] OP_LOAD_TEX   = 2'd0;
	localparam logic [1:0] OP_LOAD_LIGHT = 2'd1;
	localparam logic [1:0] OP_SPAN       = 2'd2;

	localparam logic [1:0] STS_PIX   = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_PUNT  = 2'd2;
	localparam logic [1:0] STS_WIDE  = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POW2        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd4;

	localparam logic [31:0] FRAC_MASK = 32'h0000FFFF;

	// Divider: dividend is |delta| * 2^16, divisor is the span width in 16.16.
	localparam int NUM_W  = 49;
	localparam int DIVR_W = 33;
	localparam int NLANE  = 3;
	localparam int LANE_U = 0;
	localparam int LANE_V = 1;
	localparam int LANE_L = 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CEIL,
		S_CLASS,
		S_STAT,
		S_DIV,
		S_PRE,
		S_RUN,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic       span_load;
		logic       tex_we;
		logic       lt_we;
		logic       calc_ceil;
		logic       classify;
		logic       div_start;
		logic       pre_en;
		logic       emit_pix;
		logic       emit_stat;
	} cmd_t;

	typedef struct packed {
		logic [1:0] span_code;
		logic       div_done;
		logic       pre_done;
		logic       last_pix;
		logic       advance;
		logic       s1_busy;
	} sts_t;

endpackage

// ----- hw/rtl/lats_if.sv -----
// ----------------------------------------------------------------------------
// Span engine channels
// Valid/ready channels for command items and pixel results.
// ----------------------------------------------------------------------------
interface lats_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [11:0]        mem_addr;
	logic [7:0]         mem_data;
	logic signed [31:0] left_x;
	logic signed [31:0] right_x;
	logic signed [31:0] left_u;
	logic signed [31:0] left_v;
	logic [19:0]        left_light;
	logic signed [31:0] right_u;
	logic signed [31:0] right_v;
	logic [19:0]        right_light;

	modport source(output valid, opcode, mem_addr, mem_data, left_x, right_x, left_u,
		left_v, left_light, right_u, right_v, right_light, input ready);
	modport sink(input valid, opcode, mem_addr, mem_data, left_x, right_x, left_u,
		left_v, left_light, right_u, right_v, right_light, output ready);
endinterface

interface lats_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pixel_x;
	logic [7:0]         colour;
	logic               write_enable;
	logic               last;
	logic [1:0]         status;

	modport source(output valid, pixel_x, colour, write_enable, last, status, input ready);
	modport sink(input valid, pixel_x, colour, write_enable, last, status, output ready);
endinterface

// ----- hw/rtl/lats_div.sv -----
// ----------------------------------------------------------------------------
// Span step divider
// Three restoring dividers sharing one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lats_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lats_pkg::NUM_W-1:0]  num [lats_pkg::NLANE],
	input  logic [lats_pkg::DIVR_W-1:0] dvsr,
	output logic [lats_pkg::NUM_W-1:0]  quo [lats_pkg::NLANE],
	output logic                       done
);
	import lats_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  sh_q  [NLANE];
	logic [DIVR_W-1:0] rem_q [NLANE];
	logic [DIVR_W:0]   rem_sh [NLANE];
	logic              ge     [NLANE];
	logic [DIVR_W:0]   rem_sub [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			rem_sh[i]  = {rem_q[i], sh_q[i][NUM_W-1]};
			ge[i]      = rem_sh[i] >= {1'b0, dvsr};
			rem_sub[i] = rem_sh[i] - {1'b0, dvsr};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			if (start) begin
				sh_q[i]  <= num[i];
				rem_q[i] <= '0;
			end else if (busy_q) begin
				sh_q[i]  <= {sh_q[i][NUM_W-2:0], ge[i]};
				rem_q[i] <= ge[i] ? rem_sub[i][DIVR_W-1:0] : rem_sh[i][DIVR_W-1:0];
			end
		end
	end

	assign quo  = sh_q;
	assign done = done_q;
endmodule

// ----- hw/rtl/lats_ctl.sv -----
// ----------------------------------------------------------------------------
// Span engine controller
// Sequences load, classify, divide, prestep and pixel issue for each item.
// ----------------------------------------------------------------------------
`include "lit_affine_texture_span_top_defines.svh"

module lats_ctl (
	input  logic            clk,
	input  logic            arst_n,
	lats_in_if.sink         span_in,
	input  lats_pkg::sts_t  sts,
	output lats_pkg::cmd_t  cmd
);
	import lats_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign span_in.ready = (state_q == S_IDLE);
	assign accept        = span_in.valid && span_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.tex_we    = (span_in.opcode == OP_LOAD_TEX);
					cmd.lt_we     = (span_in.opcode == OP_LOAD_LIGHT);
					cmd.span_load = (span_in.opcode == OP_SPAN);
					if (span_in.opcode == OP_SPAN) begin
						state_d = S_CEIL;
					end
				end
			end
			S_CEIL: begin
				cmd.calc_ceil = 1'b1;
				state_d       = S_CLASS;
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				if (sts.span_code == STS_PIX) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_STAT;
				end
			end
			S_STAT: begin
				cmd.emit_stat = 1'b1;
				if (sts.advance) begin
					state_d = S_DRAIN;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_PRE;
				end
			end
			S_PRE: begin
				cmd.pre_en = 1'b1;
				if (sts.pre_done) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.emit_pix = 1'b1;
				if (sts.advance && sts.last_pix) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.s1_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`LATS_ASSERT_NOW(a_idle_pipe_empty, state_q == S_IDLE, !sts.s1_busy, "pipeline busy in idle")
	`LATS_ASSERT_NEXT(a_last_to_drain, state_q == S_RUN && sts.advance && sts.last_pix, state_q == S_DRAIN, "span did not end after last pixel")
endmodule

// ----- hw/rtl/lats_dp.sv -----
// ----------------------------------------------------------------------------
// Span engine datapath
// Config registers, span setup, step divider, prestep and the pixel pipeline.
// ----------------------------------------------------------------------------
`include "lit_affine_texture_span_top_defines.svh"

module lats_dp #(
	parameter int TEX_DEPTH     = 4096,
	parameter int LIGHT_ENTRIES = 4096,
	parameter int SPAN_MAX      = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lats_pkg::cmd_t                  cmd,
	output lats_pkg::sts_t                  sts,
	input  logic                            cfg_we,
	input  logic [lats_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lats_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [11:0]                     mem_addr,
	input  logic [7:0]                      mem_data,
	input  logic signed [31:0]              left_x,
	input  logic signed [31:0]              right_x,
	input  logic signed [31:0]              left_u,
	input  logic signed [31:0]              left_v,
	input  logic [19:0]                     left_light,
	input  logic signed [31:0]              right_u,
	input  logic signed [31:0]              right_v,
	input  logic [19:0]                     right_light,
	lats_out_if.source                      pix_out
);
	import lats_pkg::*;

	// Both stores are addressed modulo their depth, which is a power of two.
	localparam int TEX_AW = $clog2(TEX_DEPTH);
	localparam int LT_AW  = $clog2(LIGHT_ENTRIES);
	localparam int CNT_W  = $clog2(SPAN_MAX + 1);

	// Configuration registers.
	logic        transparent_q;
	logic        pow2_q;
	logic [3:0]  wl_q;
	logic [3:0]  hl_q;
	logic [12:0] stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_q <= 1'b0;
			pow2_q        <= 1'b1;
			wl_q          <= 4'd6;
			hl_q          <= 4'd6;
			stride_q      <= 13'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TRANSPARENT: transparent_q <= cfg_wdata[0];
				CFG_POW2:        pow2_q        <= cfg_wdata[0];
				CFG_WIDTH_LOG2:  wl_q          <= cfg_wdata[3:0];
				CFG_HEIGHT_LOG2: hl_q          <= cfg_wdata[3:0];
				CFG_ROW_STRIDE:  stride_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Span setup.
	logic [31:0]        lx_q, rx_q;
	logic [31:0]        lft_q [NLANE];
	logic [31:0]        rgt_q [NLANE];
	logic signed [16:0] cl_q, cr_q;
	logic [DIVR_W-1:0]  dx_q;
	logic               neg_q [NLANE];
	logic [32:0]        mag_q [NLANE];
	logic [15:0]        pre_q;
	logic [1:0]         code_q;
	logic [CNT_W-1:0]   nm1_q;
	logic [CNT_W-1:0]   pix_cnt_q;
	logic [15:0]        x_q;

	logic [32:0]        lx_ext, rx_ext;
	logic [32:0]        cl_sum, cr_sum;
	logic [32:0]        delta [NLANE];
	logic signed [17:0] n_w;
	logic [1:0]         code_w;
	logic [32:0]        pre_w;

	always_comb begin
		lx_ext = {lx_q[31], lx_q};
		rx_ext = {rx_q[31], rx_q};
		cl_sum = lx_ext + {1'b0, FRAC_MASK};
		cr_sum = rx_ext + {1'b0, FRAC_MASK};
		for (int i = 0; i < NLANE; i++) begin
			delta[i] = {rgt_q[i][31], rgt_q[i]} - {lft_q[i][31], lft_q[i]};
		end
		n_w   = {cr_q[16], cr_q} - {cl_q[16], cl_q};
		pre_w = {cl_q[16:0], 16'h0000} - lx_ext;
		if (n_w == 18'sd0) begin
			code_w = STS_EMPTY;
		end else if (n_w < 18'sd0) begin
			code_w = STS_PUNT;
		end else if (n_w > 18'(SPAN_MAX)) begin
			code_w = STS_WIDE;
		end else begin
			code_w = STS_PIX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.span_load) begin
			lx_q          <= left_x;
			rx_q          <= right_x;
			lft_q[LANE_U] <= left_u;
			lft_q[LANE_V] <= left_v;
			lft_q[LANE_L] <= {12'h000, left_light};
			rgt_q[LANE_U] <= right_u;
			rgt_q[LANE_V] <= right_v;
			rgt_q[LANE_L] <= {12'h000, right_light};
		end
		if (cmd.calc_ceil) begin
			cl_q <= cl_sum[32:16];
			cr_q <= cr_sum[32:16];
			dx_q <= rx_ext - lx_ext;
			for (int i = 0; i < NLANE; i++) begin
				neg_q[i] <= delta[i][32];
				mag_q[i] <= delta[i][32] ? (~delta[i] + 33'd1) : delta[i];
			end
		end
		if (cmd.classify) begin
			code_q <= code_w;
			nm1_q  <= CNT_W'(n_w - 18'sd1);
			pre_q  <= pre_w[15:0];
		end
	end

	// Step division.
	logic [NUM_W-1:0] div_num [NLANE];
	logic [NUM_W-1:0] div_quo [NLANE];
	logic             div_done;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			div_num[i] = {mag_q[i], 16'h0000};
		end
	end

	lats_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.dvsr   (dx_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	function automatic logic [31:0] sat_step(input logic neg, input logic [NUM_W-1:0] q);
		logic [31:0] r;
		if (!neg) begin
			r = (q > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
		end else begin
			r = (q > NUM_W'(32'h80000000)) ? 32'h80000000 : (~q[31:0] + 32'd1);
		end
		return r;
	endfunction

	// Prestep: one shared multiply, then the add into the accumulator.
	logic [31:0]        step_q [NLANE];
	logic [31:0]        acc_q  [NLANE];
	logic [1:0]         pre_idx_q;
	logic [1:0]         prev_idx;
	logic signed [48:0] prod_q;
	logic               advance;
	logic               step_pix;

	assign prev_idx = pre_idx_q - 2'd1;
	assign step_pix = cmd.emit_pix && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_idx_q <= '0;
		end else if (cmd.div_start) begin
			pre_idx_q <= '0;
		end else if (cmd.pre_en) begin
			pre_idx_q <= pre_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			for (int i = 0; i < NLANE; i++) begin
				step_q[i] <= sat_step(neg_q[i], div_quo[i]);
			end
		end
		if (cmd.pre_en) begin
			if (pre_idx_q != 2'd3) begin
				prod_q <= $signed(step_q[pre_idx_q]) * $signed({1'b0, pre_q});
			end
			if (pre_idx_q != 2'd0) begin
				acc_q[prev_idx] <= lft_q[prev_idx] + prod_q[47:16];
			end
		end
		if (cmd.classify) begin
			x_q       <= cl_q[15:0];
			pix_cnt_q <= '0;
		end else if (step_pix) begin
			x_q       <= x_q + 16'd1;
			pix_cnt_q <= pix_cnt_q + 1'b1;
			for (int i = 0; i < NLANE; i++) begin
				acc_q[i] <= acc_q[i] + step_q[i];
			end
		end
	end

	// Texel address from the current accumulators.
	logic [31:0]        vi, ui, mask, ta_pow;
	logic [TEX_AW+12:0] sprod;
	logic [TEX_AW-1:0]  tex_ra, tex_wa;
	logic [LT_AW-1:0]   lt_wa, lt_ra;
	logic [23:0]        la_full;

	always_comb begin
		vi     = {{16{acc_q[LANE_V][31]}}, acc_q[LANE_V][31:16]};
		ui     = {{16{acc_q[LANE_U][31]}}, acc_q[LANE_U][31:16]};
		mask   = (32'd1 << ({1'b0, wl_q} + {1'b0, hl_q})) - 32'd1;
		ta_pow = ((vi << wl_q) + ui) & mask;
		sprod  = vi[TEX_AW-1:0] * stride_q;
		tex_ra = pow2_q ? ta_pow[TEX_AW-1:0] : (sprod[TEX_AW-1:0] + ui[TEX_AW-1:0]);
		tex_wa = TEX_AW'(mem_addr);
		lt_wa  = LT_AW'(mem_addr);
	end

	// Pixel pipeline: texel read, then light table read into the output register.
	logic [7:0]  tex_mem [TEX_DEPTH];
	logic [7:0]  lt_mem  [LIGHT_ENTRIES];
	logic        valid_s1, valid_s2;
	logic [1:0]  stat_s1, stat_s2;
	logic        last_s1, last_s2;
	logic [15:0] x_s1, x_s2;
	logic [15:0] lhi_s1;
	logic [7:0]  tex_s1;
	logic [7:0]  col_s2;
	logic        we_s2;
	logic        emit0;

	assign advance = !valid_s2 || pix_out.ready;
	assign emit0   = cmd.emit_pix || cmd.emit_stat;
	assign la_full = {lhi_s1, tex_s1};
	assign lt_ra   = la_full[LT_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.tex_we) begin
			tex_mem[tex_wa] <= mem_data;
		end
		if (advance) begin
			tex_s1 <= tex_mem[tex_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lt_we) begin
			lt_mem[lt_wa] <= mem_data;
		end
		if (advance) begin
			col_s2 <= lt_mem[lt_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= emit0;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stat_s1 <= cmd.emit_stat ? code_q : STS_PIX;
			last_s1 <= cmd.emit_stat || (pix_cnt_q == nm1_q);
			x_s1    <= cmd.emit_stat ? 16'h0000 : x_q;
			lhi_s1  <= acc_q[LANE_L][31:16];
			stat_s2 <= stat_s1;
			last_s2 <= last_s1;
			x_s2    <= x_s1;
			we_s2   <= (stat_s1 == STS_PIX) && !(transparent_q && (tex_s1 == 8'h00));
		end
	end

	assign pix_out.valid        = valid_s2;
	assign pix_out.pixel_x      = x_s2;
	assign pix_out.colour       = we_s2 ? col_s2 : 8'h00;
	assign pix_out.write_enable = we_s2;
	assign pix_out.last         = last_s2;
	assign pix_out.status       = stat_s2;

	always_comb begin
		sts.span_code = code_w;
		sts.div_done  = div_done;
		sts.pre_done  = (pre_idx_q == 2'd3);
		sts.last_pix  = (pix_cnt_q == nm1_q);
		sts.advance   = advance;
		sts.s1_busy   = valid_s1;
	end

	`LATS_ASSERT_NOW(a_stat_is_last, valid_s1 && stat_s1 != STS_PIX, last_s1, "status beat without last")
	`LATS_ASSERT_NOW(a_emit_exclusive, cmd.emit_pix, !cmd.emit_stat && !cmd.pre_en, "pixel issue overlaps setup")
endmodule

// ----- hw/rtl/lit_affine_texture_span_top.sv -----
// ----------------------------------------------------------------------------
// Lit affine texture span engine
// Draws one scanline span per command item through a texture and light table.
// ----------------------------------------------------------------------------
// The span_in channel carries command beats: texel loads, light table loads
// and span draws. Loads give no result. A span draw gives one pixel_out beat
// per covered column, or a single status beat when the span is empty, has
// negative width or is wider than SPAN_MAX. A drawn span holds the input
// through the accepting cycle, setup, the three step divisions side by side
// (49 quotient bits, then the steps are registered), the shared prestep
// multiplier, pixel issue and the drain of the texel read stage. Pixel beats
// are presented behind a two-stage texel and light table read. A status-only
// span holds the input through setup, the status beat and the drain.
// The next command is accepted once the previous span has left the texel
// read stage; the last result may still wait in the output register.
// A stalled receiver freezes the whole pixel pipeline.
// Reset returns the configuration registers to their defaults and empties
// the pipeline; the texture and light stores are not cleared and must be
// loaded before use. Configuration is written through cfg_we, cfg_idx and
// cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module lit_affine_texture_span_top #(
	parameter int TEX_DEPTH     = 4096,
	parameter int LIGHT_ENTRIES = 4096,
	parameter int SPAN_MAX      = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lats_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lats_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lats_in_if.sink                         span_in,
	lats_out_if.source                      pix_out
);
	import lats_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lats_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.span_in (span_in),
		.sts     (sts),
		.cmd     (cmd)
	);

	lats_dp #(
		.TEX_DEPTH     (TEX_DEPTH),
		.LIGHT_ENTRIES (LIGHT_ENTRIES),
		.SPAN_MAX      (SPAN_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.mem_addr    (span_in.mem_addr),
		.mem_data    (span_in.mem_data),
		.left_x      (span_in.left_x),
		.right_x     (span_in.right_x),
		.left_u      (span_in.left_u),
		.left_v      (span_in.left_v),
		.left_light  (span_in.left_light),
		.right_u     (span_in.right_u),
		.right_v     (span_in.right_v),
		.right_light (span_in.right_light),
		.pix_out     (pix_out)
	);
endmodule
